@@ hdl/hbsd_pkg.sv @@
// ----------------------------------------------------------------------------
// hbsd_pkg
// Shared types, result codes and the CRC helper of the HDLC deframer.
// ----------------------------------------------------------------------------
package hbsd_pkg;

	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_GOOD     = 2'd1;
	localparam logic [1:0] KIND_CRCERR   = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	localparam logic [1:0] REG_FLAG      = 2'd0;
	localparam logic [1:0] REG_ESCAPE    = 2'd1;
	localparam logic [1:0] REG_MASK      = 2'd2;
	localparam logic [1:0] REG_CRC_START = 2'd3;

	localparam logic [7:0]  FLAG_RESET      = 8'h7E;
	localparam logic [7:0]  ESCAPE_RESET    = 8'h7D;
	localparam logic [7:0]  MASK_RESET      = 8'h20;
	localparam logic [15:0] CRC_START_RESET = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'h8408;

	localparam int LEN_W   = 6;
	localparam int LEN_MAX = 63;

	typedef struct packed {
		logic [7:0]  flag_value;
		logic [7:0]  escape_value;
		logic [7:0]  escape_mask;
		logic [15:0] crc_start;
	} hbsd_cfg_t;

	// One queue entry: the first result of a byte, plus a trailing overflow
	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
		logic             two;
	} hbsd_entry_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} hbsd_q_stat_t;

	// Reflected CRC-CCITT update, LSB first
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ hdl/hbsd_if.sv @@
// ----------------------------------------------------------------------------
// hbsd_in_if / hbsd_out_if
// Valid/ready channels for raw bytes in and deframer results out.
// ----------------------------------------------------------------------------
interface hbsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface hbsd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic [5:0] frame_length;
	logic       run_last;

	modport source (output valid, output out_kind, output out_byte, output frame_length,
		output run_last, input ready);
	modport sink (input valid, input out_kind, input out_byte, input frame_length,
		input run_last, output ready);
endinterface

@@ hdl/hdlc_byte_stuff_deframer_crc16_top.sv @@
// ----------------------------------------------------------------------------
// hdlc_byte_stuff_deframer_crc16_top
// HDLC byte-stuffing deframer with reflected CRC-CCITT frame check.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries raw link bytes; out_ch carries results (payload byte,
//   frame good with length, CRC error, overflow), run_last marking the last
//   result of a byte. Both are valid/ready; a transfer happens when both
//   are high. Flag, escape, mask and CRC start are set over APB at byte
//   addresses 0, 4, 8 and 12; the user must set them only while the block
//   is idle; the block does not enforce this. A byte's results pass through
//   the queue and the output register. Throughput: one byte per cycle while
//   the queue is not full; a byte causes at most one result except the byte
//   that overflows a frame after payload started, which causes two. The
//   front updates unstuffing and CRC in the cycle a byte is taken; the
//   output register issues one result a cycle while out_ch.ready is high.
//   A QDEPTH-entry queue decouples the two, so a stalled receiver fills the
//   queue before in_ch.ready drops. Reset clears the unstuffing state,
//   frame count, queue, output register; all registers go to defaults.
// ----------------------------------------------------------------------------
module hdlc_byte_stuff_deframer_crc16_top
	import hbsd_pkg::*;
#(
	parameter int FRAME_MAX = 64,
	parameter int QDEPTH    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	hbsd_in_if.sink     in_ch,
	hbsd_out_if.source  out_ch
);

	hbsd_cfg_t    cfg;
	hbsd_entry_t  wr_entry;
	hbsd_entry_t  rd_entry;
	hbsd_q_stat_t stat;
	logic         accept;
	logic         push;
	logic         pop;

	assign in_ch.ready = !stat.full;
	assign accept      = in_ch.valid && in_ch.ready;

	hbsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hbsd_front #(.FRAME_MAX(FRAME_MAX)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.in_byte (in_ch.in_byte),
		.push    (push),
		.entry   (wr_entry)
	);

	hbsd_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.stat     (stat)
	);

	hbsd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.rd_entry (rd_entry),
		.pop      (pop),
		.out_ch   (out_ch)
	);

	// A non-final result is always followed at once by the overflow result
	a_second_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.run_last)
		|=> (out_ch.valid && out_ch.out_kind == KIND_OVERFLOW && out_ch.run_last))
		else $error("overflow result did not follow a non-final result");

	// Only a payload result can be followed by a second result
	a_two_after_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.run_last) |-> (out_ch.out_kind == KIND_PAYLOAD))
		else $error("non-final result is not a payload byte");

	// The front never pushes into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("queue push while full");

	// A good-frame length is only reported on a good-frame result
	a_len_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.out_kind != KIND_GOOD) |-> (out_ch.frame_length == 6'd0))
		else $error("frame length on a result other than frame good");

endmodule

@@ hdl/hbsd_cfg.sv @@
// ----------------------------------------------------------------------------
// hbsd_cfg
// APB register file: flag, escape, escape mask and CRC start value.
// ----------------------------------------------------------------------------
module hbsd_cfg
	import hbsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output hbsd_cfg_t   cfg
);

	hbsd_cfg_t  cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_value   <= FLAG_RESET;
			cfg_q.escape_value <= ESCAPE_RESET;
			cfg_q.escape_mask  <= MASK_RESET;
			cfg_q.crc_start    <= CRC_START_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_FLAG:      cfg_q.flag_value   <= pwdata[7:0];
				REG_ESCAPE:    cfg_q.escape_value <= pwdata[7:0];
				REG_MASK:      cfg_q.escape_mask  <= pwdata[7:0];
				REG_CRC_START: cfg_q.crc_start    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FLAG:      prdata = {24'h0, cfg_q.flag_value};
			REG_ESCAPE:    prdata = {24'h0, cfg_q.escape_value};
			REG_MASK:      prdata = {24'h0, cfg_q.escape_mask};
			REG_CRC_START: prdata = {16'h0, cfg_q.crc_start};
			default:       prdata = 32'h0;
		endcase
	end

endmodule

@@ hdl/hbsd_front.sv @@
// ----------------------------------------------------------------------------
// hbsd_front
// Classifies each raw byte, unstuffs it, keeps the two-byte hold line and
// the running CRC, and pushes the results of the byte as one queue entry.
// ----------------------------------------------------------------------------
module hbsd_front
	import hbsd_pkg::*;
#(
	parameter int FRAME_MAX = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  hbsd_cfg_t    cfg,
	input  logic         accept,
	input  logic [7:0]   in_byte,
	output logic         push,
	output hbsd_entry_t  entry
);

	localparam int CW = $clog2(FRAME_MAX);
	localparam int LW = (CW + 1 > 7) ? CW + 1 : 7;

	logic          esc_pend_q;
	logic [CW-1:0] count_q;
	logic [15:0]   crc_q;
	logic [7:0]    held0_q;
	logic [7:0]    held1_q;

	logic          is_flag;
	logic          is_esc;
	logic [7:0]    data;
	logic          enough;
	logic [CW:0]   cnt_inc;
	logic          ovf;
	logic [LW-1:0] len_full;
	logic [15:0]   crc_folded;

	assign is_flag    = (in_byte == cfg.flag_value);
	assign is_esc     = !is_flag && (in_byte == cfg.escape_value);
	assign data       = esc_pend_q ? (in_byte ^ cfg.escape_mask) : in_byte;
	assign enough     = (count_q >= CW'(2));
	assign cnt_inc    = {1'b0, count_q} + (CW+1)'(1);
	assign ovf        = (cnt_inc >= (CW+1)'(FRAME_MAX));
	assign len_full   = LW'(count_q) - LW'(2);
	assign crc_folded = crc_fold(crc_q, held0_q);

	always_comb begin
		push  = 1'b0;
		entry = '0;
		if (is_flag) begin
			if (!esc_pend_q && enough) begin
				push = 1'b1;
				if ({held1_q, held0_q} == crc_q) begin
					entry.kind = KIND_GOOD;
					entry.len  = (len_full > LW'(LEN_MAX)) ? LEN_W'(LEN_MAX)
						: len_full[LEN_W-1:0];
				end else begin
					entry.kind = KIND_CRCERR;
				end
			end
		end else if (!is_esc) begin
			if (enough) begin
				push       = 1'b1;
				entry.kind = KIND_PAYLOAD;
				entry.data = held0_q;
				entry.two  = ovf;
			end else if (ovf) begin
				push       = 1'b1;
				entry.kind = KIND_OVERFLOW;
			end
		end
		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pend_q <= 1'b0;
			count_q    <= '0;
			crc_q      <= CRC_START_RESET;
			held0_q    <= 8'h00;
			held1_q    <= 8'h00;
		end else if (accept) begin
			if (is_flag) begin
				esc_pend_q <= 1'b0;
				count_q    <= '0;
				crc_q      <= cfg.crc_start;
			end else if (is_esc) begin
				esc_pend_q <= 1'b1;
			end else begin
				esc_pend_q <= 1'b0;
				held0_q    <= held1_q;
				held1_q    <= data;
				if (ovf) begin
					// restart the frame; held bytes are dropped with the count
					count_q <= '0;
					crc_q   <= cfg.crc_start;
				end else begin
					count_q <= cnt_inc[CW-1:0];
					if (enough) begin
						crc_q <= crc_folded;
					end
				end
			end
		end
	end

endmodule

@@ hdl/hbsd_queue.sv @@
// ----------------------------------------------------------------------------
// hbsd_queue
// Small FIFO of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module hbsd_queue
	import hbsd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hbsd_entry_t   wr_entry,
	input  logic          pop,
	output hbsd_entry_t   rd_entry,
	output hbsd_q_stat_t  stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	hbsd_entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   fill_q;

	assign stat.full      = (fill_q == (AW+1)'(DEPTH));
	assign stat.not_empty = (fill_q != '0);
	assign rd_entry       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + (AW+1)'(1);
				2'b01:   fill_q <= fill_q - (AW+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ hdl/hbsd_back.sv @@
// ----------------------------------------------------------------------------
// hbsd_back
// Output register: takes one entry from the queue and sends its one or two
// results, the second being the overflow that ends an overlong frame.
// ----------------------------------------------------------------------------
module hbsd_back
	import hbsd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  hbsd_q_stat_t  stat,
	input  hbsd_entry_t   rd_entry,
	output logic          pop,
	hbsd_out_if.source    out_ch
);

	logic        hold_q;
	logic        second_q;
	hbsd_entry_t ent_q;
	logic        xfer;
	logic        done;

	assign xfer = out_ch.valid && out_ch.ready;
	assign done = xfer && (second_q || !ent_q.two);
	assign pop  = stat.not_empty && (!hold_q || done);

	assign out_ch.valid        = hold_q;
	assign out_ch.out_kind     = second_q ? KIND_OVERFLOW : ent_q.kind;
	assign out_ch.out_byte     = second_q ? 8'h00 : ent_q.data;
	assign out_ch.frame_length = second_q ? 6'h00 : ent_q.len;
	assign out_ch.run_last     = second_q || !ent_q.two;

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= rd_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (pop) begin
				hold_q   <= 1'b1;
				second_q <= 1'b0;
			end else if (done) begin
				hold_q   <= 1'b0;
				second_q <= 1'b0;
			end else if (xfer) begin
				// advance to the trailing overflow result
				second_q <= 1'b1;
			end
		end
	end

endmodule
